// ----- design/rhc_pkg.sv -----
package rhc_pkg;

  // Channel width and derived widths.
  localparam int CB = 8;
  localparam logic [CB-1:0] CMAX = '1;

  // Hue in 1/64 degree units.
  localparam int HUE_BITS = 15;
  localparam int HQ_BITS = 12;
  localparam logic [HQ_BITS-1:0] HUE_SIXTH = 12'd3840;
  localparam logic [HUE_BITS-1:0] HUE_BASE_GREEN = 15'd7680;
  localparam logic [HUE_BITS-1:0] HUE_BASE_BLUE = 15'd15360;
  localparam logic [HUE_BITS-1:0] HUE_FULL = 15'd23040;

  // Dividend width of both dividers, wide enough for both quotients.
  localparam int NB = (2 * CB > CB + HQ_BITS) ? 2 * CB : CB + HQ_BITS;

  // Small queues between the parts.
  localparam int Q_PTR_BITS = 1;
  localparam logic [Q_PTR_BITS:0] Q_DEPTH = 2'd2;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // Classified pixel from the front part.
  typedef struct packed {
    logic [CB-1:0] val;
    logic [CB-1:0] delta;
    logic [CB-1:0] mag;
    logic neg;
    sector_t sector;
    logic grey;
  } rhc_item_t;

  // Head of the queue between front and back.
  typedef struct packed {
    logic empty;
    rhc_item_t item;
  } rhc_mid_t;

  // Data carried alongside the divider pipeline.
  typedef struct packed {
    logic [CB-1:0] val;
    logic neg;
    sector_t sector;
    logic grey;
  } rhc_side_t;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    logic [CB-1:0] sat;
    logic [CB-1:0] val;
  } rhc_res_t;

endpackage

// ----- design/rgb_to_hsv_converter.sv -----
// RGB to HSV converter. Takes one pixel of red, green and blue per clock and
// returns value (largest channel), saturation ((max-min)*full/max, rounded to
// nearest) and hue in 1/64 degree units (0 to 23039). Grey and black pixels
// give hue and saturation of zero; ties for the largest channel go to red,
// then green. Both sides are queues: push while full is low, pop while empty
// is low. A new pixel is accepted every cycle while full is low. NB =
// max(2*CB, CB+12) is the depth of the two restoring dividers that run side
// by side one quotient bit per stage. The pipeline halts as a whole only
// when the two-entry result queue is full.
module rgb_to_hsv_converter (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [rhc_pkg::CB-1:0] red_in,
  input  logic [rhc_pkg::CB-1:0] green_in,
  input  logic [rhc_pkg::CB-1:0] blue_in,
  output logic empty,
  input  logic pop,
  output logic [rhc_pkg::HUE_BITS-1:0] hue_out,
  output logic [rhc_pkg::CB-1:0] sat_out,
  output logic [rhc_pkg::CB-1:0] val_out
);
  import rhc_pkg::*;

  rhc_mid_t mid;
  logic mid_pop;

  // Classification and the middle queue.
  rhc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .red_in  (red_in),
    .green_in(green_in),
    .blue_in (blue_in),
    .mid     (mid),
    .mid_pop (mid_pop)
  );

  // Division pipeline and the result queue.
  rhc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .mid    (mid),
    .mid_pop(mid_pop),
    .empty  (empty),
    .pop    (pop),
    .hue_out(hue_out),
    .sat_out(sat_out),
    .val_out(val_out)
  );

endmodule

// ----- design/rhc_front.sv -----
module rhc_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [rhc_pkg::CB-1:0] red_in,
  input  logic [rhc_pkg::CB-1:0] green_in,
  input  logic [rhc_pkg::CB-1:0] blue_in,
  output rhc_pkg::rhc_mid_t mid,
  input  logic mid_pop
);
  import rhc_pkg::*;

  rhc_item_t item;
  rhc_item_t entries [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_PTR_BITS:0] count;
  logic [CB-1:0] mn;
  logic [CB-1:0] lhs;
  logic [CB-1:0] rhs;
  logic wr;
  logic rd;

  // Find the largest channel, with ties going to red and then green, and
  // take the channel difference that the hue formula needs.
  always_comb begin
    if (red_in >= green_in && red_in >= blue_in) begin
      item.sector = SECT_RED;
      item.val = red_in;
      lhs = green_in;
      rhs = blue_in;
    end else if (green_in >= blue_in) begin
      item.sector = SECT_GREEN;
      item.val = green_in;
      lhs = blue_in;
      rhs = red_in;
    end else begin
      item.sector = SECT_BLUE;
      item.val = blue_in;
      lhs = red_in;
      rhs = green_in;
    end
    mn = red_in;
    if (green_in < mn) mn = green_in;
    if (blue_in < mn) mn = blue_in;
    item.delta = item.val - mn;
    item.neg = lhs < rhs;
    item.mag = item.neg ? rhs - lhs : lhs - rhs;
    item.grey = item.delta == '0;
  end

  // Two-entry queue toward the back part.
  assign full = count == Q_DEPTH;
  assign wr = push && !full;
  assign rd = mid_pop && count != '0;
  assign mid.empty = count == '0;
  assign mid.item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (Q_PTR_BITS + 1)'(wr) - (Q_PTR_BITS + 1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) entries[wr_ptr] <= item;
  end

endmodule

// ----- design/rhc_div.sv -----
module rhc_div (
  input  logic clk,
  input  logic en,
  input  logic [rhc_pkg::NB-1:0] num,
  input  logic [rhc_pkg::CB-1:0] den,
  output logic [rhc_pkg::NB-1:0] quo,
  output logic [rhc_pkg::CB-1:0] rem
);
  import rhc_pkg::*;

  logic [CB-1:0] st_rem [NB];
  logic [NB-1:0] st_num [NB];
  logic [NB-1:0] st_quo [NB];
  logic [CB-1:0] st_den [NB];

  // One quotient bit per stage, restoring long division.
  for (genvar s = 0; s < NB; s++) begin : g_stage
    logic [CB-1:0] rem_i;
    logic [NB-1:0] num_i;
    logic [NB-1:0] quo_i;
    logic [CB-1:0] den_i;
    logic [CB:0] trial;
    logic [CB:0] diff;
    logic take;

    if (s == 0) begin : g_first
      assign rem_i = '0;
      assign num_i = num;
      assign quo_i = '0;
      assign den_i = den;
    end else begin : g_next
      assign rem_i = st_rem[s-1];
      assign num_i = st_num[s-1];
      assign quo_i = st_quo[s-1];
      assign den_i = st_den[s-1];
    end

    assign trial = {rem_i, num_i[NB-1]};
    assign diff = trial - {1'b0, den_i};
    assign take = trial >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[s] <= take ? diff[CB-1:0] : trial[CB-1:0];
        st_num[s] <= {num_i[NB-2:0], 1'b0};
        st_quo[s] <= {quo_i[NB-2:0], take};
        st_den[s] <= den_i;
      end
    end
  end

  assign quo = st_quo[NB-1];
  assign rem = st_rem[NB-1];

endmodule

// ----- design/rhc_back.sv -----
module rhc_back (
  input  logic clk,
  input  logic rst,
  input  rhc_pkg::rhc_mid_t mid,
  output logic mid_pop,
  output logic empty,
  input  logic pop,
  output logic [rhc_pkg::HUE_BITS-1:0] hue_out,
  output logic [rhc_pkg::CB-1:0] sat_out,
  output logic [rhc_pkg::CB-1:0] val_out
);
  import rhc_pkg::*;

  logic [NB:0] v;
  rhc_side_t side [NB+1];
  logic [NB-1:0] hue_num;
  logic [NB-1:0] sat_num;
  logic [CB-1:0] hue_den;
  logic [CB-1:0] sat_den;
  logic [NB-1:0] hue_quo;
  logic [CB-1:0] hue_rem;
  logic [NB-1:0] sat_quo;
  logic [CB-1:0] sat_rem;
  logic en;
  rhc_side_t last;
  rhc_res_t res;
  logic [HUE_BITS-1:0] base;
  logic [HUE_BITS-1:0] qh;
  logic [HUE_BITS-1:0] ceilq;
  rhc_res_t oq [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_PTR_BITS:0] count;
  logic oq_full;
  logic wr;
  logic rd;

  // The whole pipeline moves together and halts only when a finished
  // result has nowhere to go.
  assign oq_full = count == Q_DEPTH;
  assign last = side[NB];
  assign en = !v[NB] || !oq_full;
  assign mid_pop = en && !mid.empty;
  assign wr = v[NB] && en;
  assign rd = pop && !empty;

  // Operand preparation for both divisions.
  always_ff @(posedge clk) begin
    if (en) begin
      hue_num <= NB'(mid.item.mag) * NB'(HUE_SIXTH);
      sat_num <= NB'(mid.item.delta) * NB'(CMAX) + NB'(mid.item.val >> 1);
      hue_den <= mid.item.delta;
      sat_den <= mid.item.val;
      side[0] <= '{val: mid.item.val, neg: mid.item.neg, sector: mid.item.sector,
                   grey: mid.item.grey};
    end
  end

  // Side data and valid bits follow the divider stages.
  for (genvar s = 1; s <= NB; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) side[s] <= side[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NB-1:0], !mid.empty};
    end
  end

  rhc_div u_hue_div (
    .clk(clk),
    .en (en),
    .num(hue_num),
    .den(hue_den),
    .quo(hue_quo),
    .rem(hue_rem)
  );

  rhc_div u_sat_div (
    .clk(clk),
    .en (en),
    .num(sat_num),
    .den(sat_den),
    .quo(sat_quo),
    .rem(sat_rem)
  );

  // Sector base plus the floored offset; a negative red hue wraps around.
  always_comb begin
    qh = HUE_BITS'(hue_quo[HQ_BITS-1:0]);
    ceilq = qh + HUE_BITS'(hue_rem != '0);
    case (last.sector)
      SECT_RED: base = last.neg ? HUE_FULL : '0;
      SECT_GREEN: base = HUE_BASE_GREEN;
      SECT_BLUE: base = HUE_BASE_BLUE;
      default: base = '0;
    endcase
    res.val = last.val;
    if (last.grey) begin
      res.hue = '0;
      res.sat = '0;
    end else begin
      res.hue = last.neg ? base - ceilq : base + qh;
      res.sat = sat_quo[CB-1:0];
    end
  end

  // Two-entry result queue toward the consumer.
  assign empty = count == '0;
  assign hue_out = oq[rd_ptr].hue;
  assign sat_out = oq[rd_ptr].sat;
  assign val_out = oq[rd_ptr].val;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (Q_PTR_BITS + 1)'(wr) - (Q_PTR_BITS + 1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) oq[wr_ptr] <= res;
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v))
    else $error("pipeline valid bits moved during a stall");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_DEPTH)
    else $error("result queue count beyond depth");
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    wr |-> res.hue < HUE_FULL)
    else $error("hue out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    mid_pop |-> !mid.empty && en)
    else $error("middle queue popped while empty or stalled");
`endif

endmodule
